### rtl/ttf_pkg.sv
package ttf_pkg;

	localparam int ADDR_BITS = 5;
	localparam int WEIGHT_ONE = 65536;

	typedef enum logic [2:0] {
		REG_GAIN,
		REG_BIAS,
		REG_VCC,
		REG_RRATIO,
		REG_ALPHA,
		REG_BETA,
		REG_WEIGHT,
		REG_OFFSET
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_OVF  = 2'd1,
		STAT_ROOT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_VOLT,
		S_CHECK,
		S_DIV1,
		S_KSAT,
		S_TERM,
		S_DISC,
		S_SQRT,
		S_QNUM,
		S_DIV2,
		S_TEMP,
		S_FMUL,
		S_FSUM,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_VOLT,
		OP_PROD,
		OP_DSTEP,
		OP_KSAT,
		OP_TERM,
		OP_DISC,
		OP_SSTEP,
		OP_QNUM,
		OP_TEMP,
		OP_FMUL,
		OP_FSUM
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    out_load;
		status_t res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic volt_err;
		logic beta_zero;
		logic disc_neg;
		logic div_last;
		logic sqrt_last;
	} dp_stat_t;

	typedef struct packed {
		logic [31:0]        gain;
		logic signed [31:0] bias;
		logic [30:0]        vcc;
		logic [30:0]        rratio;
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
		logic [16:0]        weight;
		logic signed [31:0] offset;
	} cfg_t;

endpackage

### rtl/ttf_if.sv
interface ttf_in_if #(parameter int ADC_BITS = 10) ();
	logic                valid;
	logic                ready;
	logic                func;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output func, output adc_sample, input ready);
	modport sink (input valid, input func, input adc_sample, output ready);
endinterface

interface ttf_out_if ();
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature;
	logic [1:0]         status;

	modport source (output valid, output temperature, output status, input ready);
	modport sink (input valid, input temperature, input status, output ready);
endinterface

### rtl/thermistor_temp_filter.sv
// A sample request (func high) is answered when the result channel is free, after the shared
// radix-4 divider has run twice with the square root between; errors end it early with a status.
// A read-only request goes from idle straight to the done state, where its result is loaded.
// One request is processed at a time: a new one is taken in the cycle after the result is
// loaded; a stalled result waits in the done state until the result channel takes the last one.
// arst_n clears the controller, loads register defaults and sets the filter to 60 degrees.
module thermistor_temp_filter #(
	parameter int ADC_BITS  = 10,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ttf_in_if.sink                        sample_ch,
	ttf_out_if.source                     result_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ttf_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ttf_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	ttf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ttf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_func   (sample_ch.func),
		.in_ready  (sample_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ttf_dp #(
		.ADC_BITS  (ADC_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg         (cfg),
		.adc_sample  (sample_ch.adc_sample),
		.temperature (result_ch.temperature),
		.status      (result_ch.status)
	);

endmodule

### rtl/ttf_regs.sv
module ttf_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ttf_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output ttf_pkg::cfg_t                   cfg
);
	import ttf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain   <= '0;
			cfg_q.bias   <= '0;
			cfg_q.vcc    <= 31'd327680;
			cfg_q.rratio <= 31'd65536;
			cfg_q.alpha  <= '0;
			cfg_q.beta   <= '0;
			cfg_q.weight <= 17'd65536;
			cfg_q.offset <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN:   cfg_q.gain   <= pwdata;
				REG_BIAS:   cfg_q.bias   <= pwdata;
				REG_VCC:    cfg_q.vcc    <= pwdata[30:0];
				REG_RRATIO: cfg_q.rratio <= pwdata[30:0];
				REG_ALPHA:  cfg_q.alpha  <= pwdata;
				REG_BETA:   cfg_q.beta   <= pwdata;
				REG_WEIGHT: cfg_q.weight <= pwdata[16:0];
				REG_OFFSET: cfg_q.offset <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAIN:   prdata = cfg_q.gain;
			REG_BIAS:   prdata = cfg_q.bias;
			REG_VCC:    prdata = {1'b0, cfg_q.vcc};
			REG_RRATIO: prdata = {1'b0, cfg_q.rratio};
			REG_ALPHA:  prdata = cfg_q.alpha;
			REG_BETA:   prdata = cfg_q.beta;
			REG_WEIGHT: prdata = {15'd0, cfg_q.weight};
			REG_OFFSET: prdata = cfg_q.offset;
		endcase
	end

endmodule

### rtl/ttf_ctrl.sv
module ttf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ttf_pkg::dp_stat_t stat,
	output ttf_pkg::dp_cmd_t  cmd
);
	import ttf_pkg::*;

	state_t  state_q, state_d;
	status_t status_q, status_d;
	logic    out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			status_q    <= status_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		status_d       = status_q;
		cmd.op         = OP_NONE;
		cmd.out_load   = 1'b0;
		cmd.res_status = status_q;
		in_ready       = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					status_d = STAT_OK;
					if (in_func) begin
						cmd.op  = OP_LOAD;
						state_d = S_MUL;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_d = S_VOLT;
			end
			S_VOLT: begin
				cmd.op  = OP_VOLT;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				priority if (stat.volt_err) begin
					status_d = STAT_OVF;
					state_d  = S_DONE;
				end else if (stat.beta_zero) begin
					status_d = STAT_ROOT;
					state_d  = S_DONE;
				end else begin
					cmd.op  = OP_PROD;
					state_d = S_DIV1;
				end
			end
			S_DIV1: begin
				cmd.op = OP_DSTEP;
				if (stat.div_last) state_d = S_KSAT;
			end
			S_KSAT: begin
				cmd.op  = OP_KSAT;
				state_d = S_TERM;
			end
			S_TERM: begin
				cmd.op  = OP_TERM;
				state_d = S_DISC;
			end
			S_DISC: begin
				cmd.op  = OP_DISC;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				if (stat.disc_neg) begin
					status_d = STAT_ROOT;
					state_d  = S_DONE;
				end else begin
					cmd.op = OP_SSTEP;
					if (stat.sqrt_last) state_d = S_QNUM;
				end
			end
			S_QNUM: begin
				cmd.op  = OP_QNUM;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				cmd.op = OP_DSTEP;
				if (stat.div_last) state_d = S_TEMP;
			end
			S_TEMP: begin
				cmd.op  = OP_TEMP;
				state_d = S_FMUL;
			end
			S_FMUL: begin
				cmd.op  = OP_FMUL;
				state_d = S_FSUM;
			end
			S_FSUM: begin
				cmd.op  = OP_FSUM;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		out_valid_d = cmd.out_load | (out_valid_q & ~out_ready);
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/ttf_dp.sv
module ttf_dp #(
	parameter int ADC_BITS  = 10,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ttf_pkg::dp_cmd_t    cmd,
	output ttf_pkg::dp_stat_t   stat,
	input  ttf_pkg::cfg_t       cfg,
	input  logic [ADC_BITS-1:0] adc_sample,
	output logic signed [31:0]  temperature,
	output logic [1:0]          status
);
	import ttf_pkg::*;

	localparam int SHIFT = 32 - FRAC_BITS;
	localparam int PW    = ADC_BITS + 32;
	localparam int VW    = PW - SHIFT;
	localparam int UW    = ((VW > 31) ? VW : 31) + 2;
	localparam logic [4:0] DIV_LAST  = 5'd31;
	localparam logic [4:0] SQRT_LAST = 5'd15;
	localparam logic signed [33:0] ONE_Q    = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] TEMP_25  = 64'sd25 <<< FRAC_BITS;
	localparam logic signed [31:0] TEMP_RST = 32'sd60 <<< FRAC_BITS;
	localparam logic [63:0] DISC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	logic [ADC_BITS-1:0] count_q;
	logic [PW-1:0]       prod_q;
	logic signed [UW-1:0] u_q;
	logic [63:0]         a2_q;
	logic [63:0]         dq_q;
	logic [34:0]         dr_q;
	logic [33:0]         dd_q;
	logic                dneg_q;
	logic [4:0]          cnt_q;
	logic signed [31:0]  k_q;
	logic signed [63:0]  t_q;
	logic                disc_neg_q;
	logic [63:0]         sx_q;
	logic [35:0]         srem_q;
	logic [31:0]         sroot_q;
	logic signed [31:0]  temp_q;
	logic signed [49:0]  pa_q;
	logic signed [49:0]  pb_q;
	logic signed [31:0]  filt_q;
	logic signed [31:0]  out_temp_q;
	logic [1:0]          out_status_q;

	logic [VW-1:0]        volt_mag;
	logic signed [UW-1:0] u_next;
	logic                 u_too_low;
	logic signed [31:0]   u32;
	logic [31:0]          u_abs;
	logic signed [32:0]   den;
	logic [62:0]          num_mag;
	logic signed [63:0]   a2_full;
	logic [63:0]          div_q;
	logic [34:0]          div_r;
	logic signed [63:0]   quo;
	logic signed [33:0]   km1;
	logic signed [63:0]   t_next;
	logic [63:0]          lim;
	logic [63:0]          t_mag;
	logic [63:0]          disc;
	logic                 disc_bad;
	logic [63:0]          sq_x;
	logic [35:0]          sq_r;
	logic [31:0]          sq_root;
	logic [35:0]          trial;
	logic signed [33:0]   diff;
	logic [33:0]          diff_mag;
	logic [31:0]          beta_mag;
	logic [16:0]          w;
	logic signed [49:0]   fsum;
	logic signed [32:0]   osum;
	logic signed [31:0]   out_val;

	assign volt_mag  = VW'(prod_q >> SHIFT);
	assign u_next    = $signed({{(UW-VW){1'b0}}, volt_mag}) + UW'(cfg.bias);
	assign u_too_low = u_q[UW-1] && (u_q[UW-2:31] != '1);
	assign u32       = u_too_low ? 32'sh8000_0000 : u_q[31:0];
	assign u_abs     = u32[31] ? (~u32 + 32'd1) : u32;
	assign den       = $signed({2'b00, cfg.vcc}) - 33'(u32);
	assign num_mag   = cfg.rratio * u_abs;
	assign a2_full   = cfg.alpha * cfg.alpha;

	// Restoring division, two quotient bits per cycle.
	always_comb begin
		div_q = dq_q;
		div_r = dr_q;
		for (int i = 0; i < 2; i++) begin
			div_r = {div_r[33:0], div_q[63]};
			div_q = {div_q[62:0], 1'b0};
			if (div_r >= {1'b0, dd_q}) begin
				div_r    = div_r - {1'b0, dd_q};
				div_q[0] = 1'b1;
			end
		end
	end

	assign quo    = dneg_q ? -$signed(dq_q) : $signed(dq_q);
	assign km1    = 34'(k_q) - ONE_Q;
	assign t_next = cfg.beta * km1;
	assign lim    = (DISC_MAX - a2_q) >> 2;
	assign t_mag  = ~t_q + 64'd1;

	always_comb begin
		disc     = '0;
		disc_bad = 1'b0;
		if (!t_q[63]) begin
			if (t_q > lim) disc = DISC_MAX;
			else disc = a2_q + (t_q << 2);
		end else begin
			if (t_mag > (a2_q >> 2)) disc_bad = 1'b1;
			else disc = a2_q - (t_mag << 2);
		end
	end

	// Digit-by-digit square root, two result bits per cycle.
	always_comb begin
		sq_x    = sx_q;
		sq_r    = srem_q;
		sq_root = sroot_q;
		trial   = '0;
		for (int i = 0; i < 2; i++) begin
			sq_r  = {sq_r[33:0], sq_x[63:62]};
			sq_x  = {sq_x[61:0], 2'b00};
			trial = {2'b00, sq_root, 2'b01};
			if (sq_r >= trial) begin
				sq_r    = sq_r - trial;
				sq_root = {sq_root[30:0], 1'b1};
			end else begin
				sq_root = {sq_root[30:0], 1'b0};
			end
		end
	end

	assign diff     = $signed({2'b00, sroot_q}) - 34'(cfg.alpha);
	assign diff_mag = diff[33] ? (~diff + 34'd1) : diff;
	assign beta_mag = cfg.beta[31] ? (~cfg.beta + 32'd1) : cfg.beta;
	assign w        = (cfg.weight > 17'(WEIGHT_ONE)) ? 17'(WEIGHT_ONE) : cfg.weight;
	assign fsum     = pa_q + pb_q + 50'sd32768;
	assign osum     = 33'(filt_q) + 33'(cfg.offset);
	assign out_val  = (osum[32] != osum[31]) ?
		(osum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : osum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= TEMP_RST;
		end else if (cmd.op == OP_FSUM) begin
			filt_q <= fsum[47:16];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: count_q <= adc_sample;
			OP_MUL:  prod_q <= count_q * cfg.gain;
			OP_VOLT: u_q <= u_next;
			OP_PROD: begin
				a2_q   <= a2_full;
				dq_q   <= {1'b0, num_mag};
				dr_q   <= '0;
				dd_q   <= 34'(den);
				dneg_q <= u32[31];
				cnt_q  <= '0;
			end
			OP_DSTEP: begin
				dq_q  <= div_q;
				dr_q  <= div_r;
				cnt_q <= cnt_q + 5'd1;
			end
			OP_KSAT: k_q <= sat32(quo);
			OP_TERM: t_q <= t_next;
			OP_DISC: begin
				sx_q       <= disc;
				srem_q     <= '0;
				sroot_q    <= '0;
				disc_neg_q <= disc_bad;
				cnt_q      <= '0;
			end
			OP_SSTEP: begin
				sx_q    <= sq_x;
				srem_q  <= sq_r;
				sroot_q <= sq_root;
				cnt_q   <= cnt_q + 5'd1;
			end
			OP_QNUM: begin
				dq_q   <= 64'(diff_mag) << FRAC_BITS;
				dr_q   <= '0;
				dd_q   <= {1'b0, beta_mag, 1'b0};
				dneg_q <= diff[33] ^ cfg.beta[31];
				cnt_q  <= '0;
			end
			OP_TEMP: temp_q <= sat32(quo + TEMP_25);
			OP_FMUL: begin
				pa_q <= $signed({1'b0, w}) * temp_q;
				pb_q <= $signed({1'b0, 17'(WEIGHT_ONE) - w}) * filt_q;
			end
			OP_FSUM: ;
			OP_NONE: ;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_temp_q   <= out_val;
			out_status_q <= cmd.res_status;
		end
	end

	assign stat.volt_err  = (u_q >= $signed({{(UW-31){1'b0}}, cfg.vcc}));
	assign stat.beta_zero = (cfg.beta == '0);
	assign stat.disc_neg  = disc_neg_q;
	assign stat.div_last  = (cnt_q == DIV_LAST);
	assign stat.sqrt_last = (cnt_q == SQRT_LAST);

	assign temperature = out_temp_q;
	assign status      = out_status_q;

endmodule

### rtl/ttf_chk.sv
module ttf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_func,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_temp,
	input logic [1:0]  out_status
);
	import ttf_pkg::*;

	logic in_acc;
	assign in_acc = in_valid & in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_status))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second request taken while busy");

	a_read_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_func && !out_valid |-> ##2 out_valid)
		else $error("read-only request not answered in two cycles");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_func && !out_valid |-> ##2 (out_status == STAT_OK))
		else $error("read-only request reported an error");

endmodule

bind thermistor_temp_filter ttf_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.in_func    (sample_ch.func),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.out_temp   (result_ch.temperature),
	.out_status (result_ch.status)
);
